>>> rtl/core/ffbp_pkg.sv
// shared constants and types for the first-fit bin packer
`timescale 1ns / 1ps

package ffbp_pkg;

	// default number of bins and width of sizes and fills
	localparam int unsigned MAX_BINS_DEF  = 64;
	localparam int unsigned SIZE_BITS_DEF = 40;

	// fixed field widths on the stream ports
	localparam int unsigned ITEM_SIZE_W = 40;
	localparam int unsigned BIN_INDEX_W = 6;
	localparam int unsigned BIN_FILL_W  = 40;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned CAP_W       = 40;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERSIZE = 2'd1,
		STATUS_NO_BIN   = 2'd2
	} status_t;

endpackage

>>> rtl/core/first_fit_bin_packer.sv
// first-fit bin packer: sequencer, shared adder and compare, result register
//
// usage: each request on the slave stream carries an item size in s_tdata and
// a start-of-run flag in s_tuser. when the flag is set every bin is closed
// before the item is placed. the item goes into the lowest-numbered open bin
// that still has room under the capacity, or opens the next bin if one is left;
// with no bin left, or for an item over the capacity, the status flags an error.
// one result request leaves on the master stream for every input request. the
// capacity register is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the block is idle, as the block does not enforce this;
// it resets to all ones. a request passes through the check state, one scan
// step per open bin examined (none for an oversize item or the first bin of
// a run, at most MAX_BINS) and the output state that loads the output register.
// the fill totals live in a single-port-read memory and one adder and
// comparator walk them one bin a cycle, so s_tready is low while an item runs.
// the result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver (m_tready low) holds the block once the next
// result is ready. reset closes all bins and empties the output register.
`timescale 1ns / 1ps

module first_fit_bin_packer #(
	parameter int unsigned MAX_BINS  = ffbp_pkg::MAX_BINS_DEF,
	parameter int unsigned SIZE_BITS = ffbp_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// capacity register write
	input  logic        cfg_wr_en,
	input  logic [39:0] cfg_wr_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [39:0] item_size
	input  logic        s_tuser,   // [0] start_run
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [5:0] bin_index, [45:6] bin_fill, [47:46] zero
	output logic [2:0]  m_tuser    // [0] opened_bin, [2:1] status
);

	localparam int unsigned IW = $clog2(MAX_BINS);
	localparam int unsigned CW = $clog2(MAX_BINS + 1);
	localparam logic [63:0] CAP_RST64 =
		((64'd1 << ffbp_pkg::CAP_W) - 64'd1) & ((64'd1 << SIZE_BITS) - 64'd1);
	localparam logic [SIZE_BITS-1:0] CAP_RST = CAP_RST64[SIZE_BITS-1:0];
	localparam logic [CW-1:0] BINS_FULL = CW'(MAX_BINS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [SIZE_BITS-1:0] cap_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [CW-1:0]        cnt_q;
	logic [IW-1:0]        ptr_q;

	// held result until the output register is free
	logic [IW-1:0]          res_idx_q;
	logic                   res_open_q;
	logic [SIZE_BITS-1:0]   res_fill_q;
	ffbp_pkg::status_t      res_status_q;

	logic                 m_tvalid_q;
	logic [47:0]          m_tdata_q;
	logic [2:0]           m_tuser_q;

	logic [63:0]          size_in64;
	logic [63:0]          cfg_in64;
	logic [63:0]          res_idx64;
	logic [63:0]          res_fill64;
	logic [SIZE_BITS-1:0] rd_data;
	logic [SIZE_BITS:0]   sum;
	logic                 fits;
	logic                 oversize;
	logic [CW-1:0]        ptr_next_cnt;
	logic                 scan_last;
	logic                 bins_full;
	logic                 do_open;
	logic                 mem_wr_en;
	logic [IW-1:0]        mem_wr_addr;
	logic [SIZE_BITS-1:0] mem_wr_data;
	logic [IW-1:0]        mem_rd_addr;
	logic                 out_free;

	// field extension and truncation to the internal width
	assign size_in64  = 64'(s_tdata);
	assign cfg_in64   = 64'(cfg_wr_data);
	assign res_idx64  = 64'(res_idx_q);
	assign res_fill64 = 64'(res_fill_q);

	// shared adder and comparator
	assign sum      = {1'b0, rd_data} + {1'b0, size_q};
	assign fits     = sum <= {1'b0, cap_q};
	assign oversize = size_q > cap_q;

	// scan bookkeeping
	assign ptr_next_cnt = CW'(ptr_q) + CW'(1);
	assign scan_last    = ptr_next_cnt == cnt_q;
	assign bins_full    = cnt_q == BINS_FULL;
	assign do_open = ((state_q == ST_CHECK) && !oversize && (cnt_q == '0)) ||
		((state_q == ST_SCAN) && !fits && scan_last && !bins_full);

	// memory port control
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = ptr_q;
		mem_wr_data = sum[SIZE_BITS-1:0];
		if (do_open) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = cnt_q[IW-1:0];
			mem_wr_data = size_q;
		end else if ((state_q == ST_SCAN) && fits) begin
			mem_wr_en = 1'b1;
		end
	end

	assign mem_rd_addr = (state_q == ST_SCAN) ? IW'(ptr_q + 1'b1) : '0;

	ffbp_fill_mem #(
		.MAX_BINS  (MAX_BINS),
		.SIZE_BITS (SIZE_BITS)
	) u_fill_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// sequencer, capacity register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cap_q        <= CAP_RST;
			size_q       <= '0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			res_idx_q    <= '0;
			res_open_q   <= 1'b0;
			res_fill_q   <= '0;
			res_status_q <= ffbp_pkg::STATUS_OK;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_in64[SIZE_BITS-1:0];
			end
			// drained result, unless a new one is loaded below
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						size_q  <= size_in64[SIZE_BITS-1:0];
						if (s_tuser) begin
							cnt_q <= '0;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					ptr_q <= '0;
					if (oversize) begin
						res_idx_q    <= '0;
						res_open_q   <= 1'b0;
						res_fill_q   <= '0;
						res_status_q <= ffbp_pkg::STATUS_OVERSIZE;
						state_q      <= ST_OUT;
					end else if (do_open) begin
						res_idx_q    <= cnt_q[IW-1:0];
						res_open_q   <= 1'b1;
						res_fill_q   <= size_q;
						res_status_q <= ffbp_pkg::STATUS_OK;
						cnt_q        <= cnt_q + CW'(1);
						state_q      <= ST_OUT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fits) begin
						res_idx_q    <= ptr_q;
						res_open_q   <= 1'b0;
						res_fill_q   <= sum[SIZE_BITS-1:0];
						res_status_q <= ffbp_pkg::STATUS_OK;
						state_q      <= ST_OUT;
					end else if (!scan_last) begin
						ptr_q <= IW'(ptr_q + 1'b1);
					end else if (bins_full) begin
						res_idx_q    <= '0;
						res_open_q   <= 1'b0;
						res_fill_q   <= '0;
						res_status_q <= ffbp_pkg::STATUS_NO_BIN;
						state_q      <= ST_OUT;
					end else begin
						res_idx_q    <= cnt_q[IW-1:0];
						res_open_q   <= 1'b1;
						res_fill_q   <= size_q;
						res_status_q <= ffbp_pkg::STATUS_OK;
						cnt_q        <= cnt_q + CW'(1);
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00,
							res_fill64[ffbp_pkg::BIN_FILL_W-1:0],
							res_idx64[ffbp_pkg::BIN_INDEX_W-1:0]};
						m_tuser_q  <= {res_status_q, res_open_q};
						state_q    <= ST_IDLE;
					end else if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/core/ffbp_fill_mem.sv
// fill total store: one write port, one registered read port
`timescale 1ns / 1ps

module ffbp_fill_mem #(
	parameter int unsigned MAX_BINS  = ffbp_pkg::MAX_BINS_DEF,
	parameter int unsigned SIZE_BITS = ffbp_pkg::SIZE_BITS_DEF,
	localparam int unsigned IW = $clog2(MAX_BINS)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_addr,
	input  logic [SIZE_BITS-1:0] wr_data,
	input  logic [IW-1:0]        rd_addr,
	output logic [SIZE_BITS-1:0] rd_data
);

	logic [SIZE_BITS-1:0] mem [MAX_BINS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sim/tb.sv
// self-checking testbench for the first-fit bin packer: directed table, random runs, scoreboard
`timescale 1ns / 1ps

module tb;

	localparam int unsigned NBINS    = ffbp_pkg::MAX_BINS_DEF;
	localparam logic [39:0] FULL_CAP = 40'hFF_FFFF_FFFF;
	localparam int unsigned PHASES   = 6;
	localparam int unsigned PHASE_ITEMS = 325;
	localparam int unsigned HOLD_AFTER  = 300;
	localparam int unsigned HOLD_CYCLES = 400;

	// one placement outcome as the result stream carries it
	typedef struct {
		logic [5:0]  index;
		logic        opened;
		logic [39:0] fill;
		ffbp_pkg::status_t status;
	} placement_t;

	// directed stimulus row: either a capacity write or a run of identical items
	typedef struct {
		bit          cap_write;
		logic [39:0] value;
		logic        start;
		int unsigned count;
		bit          typed;
		logic [5:0]  want_index;
		logic        want_opened;
		logic [39:0] want_fill;
		ffbp_pkg::status_t want_status;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [39:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [39:0] item_size
	logic        s_tuser;   // [0] start_run
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // [5:0] bin_index, [45:6] bin_fill, [47:46] zero
	logic [2:0]  m_tuser;   // [0] opened_bin, [2:1] status

	// packer model state
	logic [39:0] bin_level [NBINS];
	int unsigned bins_open;
	logic [39:0] capacity_model;

	placement_t  pending_placements [$];
	int unsigned mismatches;
	int unsigned results_taken;
	bit          feed_steady;
	bit          drain_steady;

	first_fit_bin_packer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// first-fit placement of one item, updating the model bins
	function automatic placement_t place_item(input logic [39:0] size, input logic start);
		placement_t  r;
		logic [40:0] total;
		r.index  = '0;
		r.opened = 1'b0;
		r.fill   = '0;
		r.status = ffbp_pkg::STATUS_OK;
		if (start)
			bins_open = 0;
		if (size > capacity_model) begin
			r.status = ffbp_pkg::STATUS_OVERSIZE;
			return r;
		end
		for (int unsigned b = 0; b < bins_open; b++) begin
			total = {1'b0, bin_level[b]} + {1'b0, size};
			if (total <= {1'b0, capacity_model}) begin
				bin_level[b] = total[39:0];
				r.index = b[5:0];
				r.fill  = total[39:0];
				return r;
			end
		end
		if (bins_open >= NBINS) begin
			r.status = ffbp_pkg::STATUS_NO_BIN;
			return r;
		end
		bin_level[bins_open] = size;
		r.index  = bins_open[5:0];
		r.opened = 1'b1;
		r.fill   = size;
		bins_open++;
		return r;
	endfunction

	function automatic int unsigned draw_gap(input bit steady);
		return steady ? 0 : $urandom_range(0, 6);
	endfunction

	// item sizes spread around the current capacity
	function automatic logic [39:0] draw_size(input logic [39:0] cap);
		logic [63:0] wide;
		logic [63:0] span;
		wide = {$urandom, $urandom};
		span = {24'd0, cap} + 64'd1;
		case ($urandom_range(0, 11))
			0:       return wide[39:0];
			1:       return '0;
			2:       return cap;
			3:       return cap + 40'd1;
			4:       return (cap >= 40'd8) ? cap - 40'(wide % 8) : 40'(wide % span);
			5, 6:    return 40'(wide % span);
			default: return 40'(wide % (span / 4 + 1));
		endcase
	endfunction

	// offer one request and record its expected placement once accepted
	task automatic push_item(input logic [39:0] size, input logic start, input bit typed,
	                         input placement_t want);
		int unsigned gap;
		placement_t  predicted;
		gap = draw_gap(feed_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= size;
		s_tuser  <= start;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		predicted = place_item(size, start);
		pending_placements.insert(pending_placements.size(), typed ? want : predicted);
	endtask

	// capacity write once every result is out
	task automatic set_capacity(input logic [39:0] value);
		s_tvalid <= 1'b0;
		while (pending_placements.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		capacity_model = value;
		cfg_wr_en <= 1'b0;
	endtask

	// directed cases: extremes, zero capacity, bins exhausted, capacity lowered mid-run
	stim_row_t plan [26] = '{
		'{0, 40'd0,     0, 1,  1, 6'd0, 1'b1, 40'd0,     ffbp_pkg::STATUS_OK},
		'{0, FULL_CAP,  0, 1,  1, 6'd0, 1'b0, FULL_CAP,  ffbp_pkg::STATUS_OK},
		'{0, 40'd1,     0, 1,  1, 6'd1, 1'b1, 40'd1,     ffbp_pkg::STATUS_OK},
		'{0, 40'd0,     0, 1,  1, 6'd0, 1'b0, FULL_CAP,  ffbp_pkg::STATUS_OK},
		'{0, FULL_CAP,  1, 1,  1, 6'd0, 1'b1, FULL_CAP,  ffbp_pkg::STATUS_OK},
		'{0, 40'd5,     1, 1,  1, 6'd0, 1'b1, 40'd5,     ffbp_pkg::STATUS_OK},
		'{1, 40'd0,     0, 1,  0, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OK},
		'{0, 40'd1,     0, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OVERSIZE},
		'{0, FULL_CAP,  0, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OVERSIZE},
		'{0, 40'd0,     0, 1,  1, 6'd1, 1'b1, 40'd0,     ffbp_pkg::STATUS_OK},
		'{0, 40'd0,     1, 1,  1, 6'd0, 1'b1, 40'd0,     ffbp_pkg::STATUS_OK},
		'{1, 40'd10,    0, 1,  0, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OK},
		'{0, 40'd11,    1, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OVERSIZE},
		'{0, 40'd10,    0, 1,  1, 6'd0, 1'b1, 40'd10,    ffbp_pkg::STATUS_OK},
		'{0, 40'd10,    0, 63, 0, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OK},
		'{0, 40'd1,     0, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_NO_BIN},
		'{0, 40'd0,     0, 1,  1, 6'd0, 1'b0, 40'd10,    ffbp_pkg::STATUS_OK},
		'{0, 40'd11,    0, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OVERSIZE},
		'{1, FULL_CAP,  0, 1,  0, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OK},
		'{0, 40'd5,     0, 1,  1, 6'd0, 1'b0, 40'd15,    ffbp_pkg::STATUS_OK},
		'{1, 40'd1,     0, 1,  0, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OK},
		'{0, 40'd1,     0, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_NO_BIN},
		'{0, 40'd0,     0, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_NO_BIN},
		'{0, 40'd1,     1, 1,  1, 6'd0, 1'b1, 40'd1,     ffbp_pkg::STATUS_OK},
		'{0, 40'd0,     0, 1,  1, 6'd0, 1'b0, 40'd1,     ffbp_pkg::STATUS_OK},
		'{0, 40'd2,     0, 1,  1, 6'd0, 1'b0, 40'd0,     ffbp_pkg::STATUS_OVERSIZE}
	};

	// stimulus: reset, directed table, random phases, drain and verdict
	initial begin
		logic [39:0] phase_caps [PHASES];
		logic [63:0] wide;
		placement_t  want;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= 1'b0;
		mismatches     = 0;
		bins_open      = 0;
		capacity_model = FULL_CAP;
		feed_steady    = 1'b0;
		drain_steady   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].cap_write) begin
				set_capacity(plan[i].value);
			end else begin
				want.index  = plan[i].want_index;
				want.opened = plan[i].want_opened;
				want.fill   = plan[i].want_fill;
				want.status = plan[i].want_status;
				repeat (plan[i].count)
					push_item(plan[i].value, plan[i].start, plan[i].typed, want);
			end
		end

		wide = {$urandom, $urandom};
		phase_caps = '{40'd1000, FULL_CAP, 40'd1, 40'd64, wide[39:0], 40'd3};
		for (int unsigned p = 0; p < PHASES; p++) begin
			set_capacity(phase_caps[p]);
			feed_steady  = ($urandom_range(0, 3) == 0);
			drain_steady = ($urandom_range(0, 3) == 0);
			// long runs without a clear so that the bins fill up
			repeat (PHASE_ITEMS)
				push_item(draw_size(capacity_model), ($urandom_range(0, 99) == 0), 1'b0, want);
		end
		s_tvalid <= 1'b0;

		while (pending_placements.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("first_fit_bin_packer test passed");
		else
			$display("first_fit_bin_packer test failed");
		$finish;
	end

	// result sink with random stalls, one long hold-off, and the field checks
	initial begin
		int unsigned stall;
		bit          held;
		logic [47:0] got_data;
		logic [2:0]  got_user;
		placement_t  want;
		m_tready <= 1'b0;
		results_taken = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// hold off long enough for the block to back up its input
			if (!held && results_taken == HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end
			stall = draw_gap(drain_steady);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid)
				@(negedge clk);
			got_data = m_tdata;
			got_user = m_tuser;
			@(posedge clk);
			results_taken++;
			if (pending_placements.size() == 0) begin
				$error("result request with no placement expected");
				mismatches++;
			end else begin
				want = pending_placements.pop_front();
				if (got_data[5:0] !== want.index) begin
					$error("bin_index: expected %0d, got %0d", want.index, got_data[5:0]);
					mismatches++;
				end
				if (got_user[0] !== want.opened) begin
					$error("opened_bin: expected %0d, got %0d", want.opened, got_user[0]);
					mismatches++;
				end
				if (got_data[45:6] !== want.fill) begin
					$error("bin_fill: expected %0d, got %0d", want.fill, got_data[45:6]);
					mismatches++;
				end
				if (got_user[2:1] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got_user[2:1]);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("first_fit_bin_packer test failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ffbp_pkg.sv
rtl/core/ffbp_fill_mem.sv
rtl/core/first_fit_bin_packer.sv
sim/tb.sv
